// ===== rtl/svmix_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sample voice mixer.
package svmix_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ADDR_W      = 12;
    localparam int LEN_W       = 13;
    localparam int MEM_DEPTH   = 4096;
    localparam int VOICE_W     = 3;
    localparam int MASK_W      = 8;
    localparam int VOICES_DEF  = 8;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Control from the sequencer to the voice slot file.
    typedef struct packed {
        logic              start_en;
        logic              stop_en;
        logic              step_en;
        logic [ADDR_W-1:0] clip_start;
        logic [LEN_W-1:0]  clip_length;
        logic              loop_enable;
    } vf_ctrl_t;

endpackage

// ===== rtl/sample_voice_mixer_top.sv =====
`timescale 1ns / 1ps
// A tick command walks the voice slots one per cycle, then its result is loaded into the
// output register once the output is free (out_valid low or out_ready high), and only
// then is the next command taken, so a new tick is not accepted while one is in progress.
// Write, start and stop commands complete in the cycle they are accepted.
// Reset clears all voice active flags, the sequencer and the output valid;
// the sample memory holds no reset value and must be written before it plays.
module sample_voice_mixer_top
    import svmix_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 cmd,
    input  logic [ADDR_W-1:0]          mem_addr,
    input  logic signed [SAMPLE_W-1:0] mem_data,
    input  logic [VOICE_W-1:0]         voice,
    input  logic [ADDR_W-1:0]          clip_start,
    input  logic [LEN_W-1:0]           clip_length,
    input  logic                       loop_enable,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic [MASK_W-1:0]          active_mask
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST_SLOT = VW'(VOICES - 1);

    state_t state_reg;
    state_t state_next;
    logic [VW-1:0] slot_reg;
    logic [VW-1:0] slot_next;
    logic pend_reg;
    logic pend_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [MASK_W-1:0] active_mask_reg;

    logic accept;
    logic acc_clr;
    logic load_out;
    logic mem_we;
    logic out_free;
    vf_ctrl_t vf_ctrl;

    logic [VW+VOICE_W-1:0] voice_ext;
    logic [VW-1:0] cmd_idx;
    logic voice_hit;

    logic cur_active;
    logic [ADDR_W-1:0] cur_addr;
    logic [VOICES-1:0] active_vec;
    logic [MASK_W-1:0] mask_now;
    logic signed [SAMPLE_W-1:0] acc_sum;

    logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    assign voice_ext = {{VW{1'b0}}, voice};
    assign cmd_idx   = voice_ext[VW-1:0];
    assign voice_hit = voice_ext < (VW+VOICE_W)'(VOICES);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next          = state_reg;
        slot_next           = slot_reg;
        in_ready            = 1'b0;
        acc_clr             = 1'b0;
        load_out            = 1'b0;
        mem_we              = 1'b0;
        vf_ctrl             = '0;
        vf_ctrl.clip_start  = clip_start;
        vf_ctrl.clip_length = clip_length;
        vf_ctrl.loop_enable = loop_enable;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (cmd_t'(cmd))
                        CMD_TICK:
                        begin
                            acc_clr    = 1'b1;
                            slot_next  = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_WRITE: mem_we = 1'b1;
                        CMD_START: vf_ctrl.start_en = voice_hit;
                        CMD_STOP:  vf_ctrl.stop_en = voice_hit;
                        default:   mem_we = 1'b0;
                    endcase
                end
            end
            ST_SCAN:
            begin
                vf_ctrl.step_en = 1'b1;
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    slot_next = slot_reg + VW'(1);
                end
            end
            ST_DRAIN:
            begin
                // The last slot's word is added to the sum in this cycle.
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pend_next = (state_reg == ST_SCAN) && cur_active;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
        rd_data_reg <= mem[cur_addr];
    end

    svmix_voice_file #(
        .VOICES (VOICES),
        .VW     (VW)
    ) u_voice_file (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (vf_ctrl),
        .cmd_idx    (cmd_idx),
        .slot_idx   (slot_reg),
        .cur_active (cur_active),
        .cur_addr   (cur_addr),
        .active     (active_vec)
    );

    svmix_sat_acc u_sat_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (acc_clr),
        .add_en   (pend_reg),
        .add_data (rd_data_reg),
        .sum      (acc_sum)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < VOICES)
            begin : g_slot
                assign mask_now[gi] = active_vec[gi];
            end
            else
            begin : g_none
                assign mask_now[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sample_out_reg  <= acc_sum;
            active_mask_reg <= mask_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign active_mask = active_mask_reg;

endmodule

// ===== rtl/svmix_sat_acc.sv =====
`timescale 1ns / 1ps
// Shared saturating accumulator that sums one sample word per beat.
module svmix_sat_acc
    import svmix_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clr,
    input  logic                       add_en,
    input  logic signed [SAMPLE_W-1:0] add_data,
    output logic signed [SAMPLE_W-1:0] sum
);

    logic signed [SAMPLE_W-1:0] sum_reg;
    logic signed [SAMPLE_W-1:0] sum_next;
    logic signed [SAMPLE_W:0]   wide_sum;

    always_comb
    begin
        wide_sum = {sum_reg[SAMPLE_W-1], sum_reg} + {add_data[SAMPLE_W-1], add_data};
        sum_next = sum_reg;
        if (clr)
        begin
            sum_next = '0;
        end
        else if (add_en)
        begin
            // The two top bits differ only when the sum left the word range.
            if (wide_sum[SAMPLE_W] != wide_sum[SAMPLE_W-1])
            begin
                sum_next = wide_sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
            end
            else
            begin
                sum_next = wide_sum[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/svmix_voice_file.sv =====
`timescale 1ns / 1ps
// Voice slot registers with start, stop and per-slot advance logic.
module svmix_voice_file
    import svmix_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  vf_ctrl_t          ctrl,
    input  logic [VW-1:0]     cmd_idx,
    input  logic [VW-1:0]     slot_idx,
    output logic              cur_active,
    output logic [ADDR_W-1:0] cur_addr,
    output logic [VOICES-1:0] active
);

    logic [VOICES-1:0] act_reg;
    logic [VOICES-1:0] act_next;
    logic [ADDR_W-1:0] start_reg [VOICES];
    logic [LEN_W-1:0]  len_reg   [VOICES];
    logic [LEN_W-1:0]  pos_reg   [VOICES];
    logic              loop_reg  [VOICES];

    logic [LEN_W-1:0]  cur_pos;
    logic [LEN_W:0]    pos_inc;
    logic              at_end;
    logic [ADDR_W-1:0] sum_addr;

    always_comb
    begin
        cur_pos    = pos_reg[slot_idx];
        cur_active = act_reg[slot_idx];
        pos_inc    = {1'b0, cur_pos} + (LEN_W+1)'(1);
        at_end     = pos_inc >= {1'b0, len_reg[slot_idx]};
        // Clip addresses wrap at the memory size.
        sum_addr   = start_reg[slot_idx] + cur_pos[ADDR_W-1:0];
        cur_addr   = sum_addr;
    end

    always_comb
    begin
        act_next = act_reg;
        if (ctrl.start_en)
        begin
            act_next[cmd_idx] = (ctrl.clip_length != '0);
        end
        else if (ctrl.stop_en)
        begin
            act_next[cmd_idx] = 1'b0;
        end
        else if (ctrl.step_en && cur_active && at_end && !loop_reg[slot_idx])
        begin
            act_next[slot_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start_en)
        begin
            start_reg[cmd_idx] <= ctrl.clip_start;
            len_reg[cmd_idx]   <= ctrl.clip_length;
            pos_reg[cmd_idx]   <= '0;
            loop_reg[cmd_idx]  <= ctrl.loop_enable;
        end
        else if (ctrl.step_en && cur_active)
        begin
            pos_reg[slot_idx] <= at_end ? '0 : pos_inc[LEN_W-1:0];
        end
    end

    assign active = act_reg;

endmodule
